@@ rtl/core/sse_pkg.sv @@
package sse_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_SCAN,
    ST_DRAIN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_HOLD
  } sse_state_t;

  // Qualifies the word coming back from the element RAM during a scan.
  typedef struct packed {
    logic vld;
    logic first;
  } sse_scan_ctl_t;

  localparam int unsigned VALUE_W = 32;

endpackage

@@ rtl/core/sse_ram.sv @@
module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sse_min_unit.sv @@
module sse_min_unit #(
  parameter int unsigned AW = 6
) (
  input  logic                        clk,
  input  sse_pkg::sse_scan_ctl_t      ctl,
  input  logic [AW-1:0]               idx,
  input  logic [sse_pkg::VALUE_W-1:0] rdata,
  output logic [sse_pkg::VALUE_W-1:0] min_val,
  output logic [AW-1:0]               min_idx,
  output logic [sse_pkg::VALUE_W-1:0] head_val
);

  // The first word of a pass is the element at the head position; it seeds
  // the minimum. Only a strictly smaller value replaces it, so the earliest
  // minimum wins.
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (ctl.first) begin
        min_val  <= rdata;
        min_idx  <= idx;
        head_val <= rdata;
      end else if ($signed(min_val) > $signed(rdata)) begin
        min_val <= rdata;
        min_idx <= idx;
      end
    end
  end

endmodule

@@ rtl/core/selection_sort_engine.sv @@
// Selection sort engine: collects up to MAX_ELEMENTS signed Q16.16 values, sorts, streams out.
// Loading accepts an input request whenever one is offered; the closing request starts the sort,
// or goes straight to output for a list of fewer than two. Sorting uses one RAM read port and
// one comparator; each pass swaps the tail's minimum to the head, and each result is held until taken.
// One list is handled at a time; no input is taken while sorting or emitting.
// Synchronous active-high reset empties the list and clears the overflow flag; the RAM is not cleared.
module selection_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic        s_tlast,  // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] sorted_value
  output logic        m_tlast,  // last_result
  output logic        m_tuser   // [0] overflow
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned VW = sse_pkg::VALUE_W;

  sse_pkg::sse_state_t    state, state_next;
  logic [CW-1:0]          count, count_next;
  logic                   ovf, ovf_next;
  logic [AW-1:0]          i, i_next;
  logic [AW-1:0]          j, j_next;
  logic [AW-1:0]          k, k_next;
  sse_pkg::sse_scan_ctl_t rd_ctl, rd_ctl_next;
  logic [AW-1:0]          rd_idx;
  logic                   out_valid, out_valid_next;
  logic [VW-1:0]          out_data;
  logic                   out_last;
  logic                   out_ovf;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VW-1:0]          ram_rdata;

  logic [VW-1:0]          min_val;
  logic [AW-1:0]          min_idx;
  logic [VW-1:0]          head_val;

  logic                   in_acc;
  logic                   out_acc;
  logic                   full;
  logic [CW-1:0]          count_after;
  logic                   k_is_last;

  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;
  assign full      = (count == CW'(MAX_ELEMENTS));
  assign k_is_last = (CW'(k) == count - CW'(1));
  assign count_after = full ? count : count + CW'(1);

  sse_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sse_min_unit #(
    .AW (AW)
  ) u_min (
    .clk      (clk),
    .ctl      (rd_ctl),
    .idx      (rd_idx),
    .rdata    (ram_rdata),
    .min_val  (min_val),
    .min_idx  (min_idx),
    .head_val (head_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sse_pkg::ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      rd_ctl    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      rd_ctl    <= rd_ctl_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    i      <= i_next;
    j      <= j_next;
    k      <= k_next;
    rd_idx <= ram_raddr;
    if (state == sse_pkg::ST_OUT_CAP) begin
      out_data <= ram_rdata;
      out_last <= k_is_last;
      out_ovf  <= ovf;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    out_valid_next = out_valid;
    ram_we         = 1'b0;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = s_tdata;
    ram_raddr      = i;
    rd_ctl_next    = '0;
    s_tready       = 1'b0;

    case (state)
      sse_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (in_acc) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end
          if (s_tlast) begin
            i_next = '0;
            k_next = '0;
            if (count_after >= CW'(2)) begin
              state_next = sse_pkg::ST_PASS;
            end else begin
              state_next = sse_pkg::ST_OUT_RD;
            end
          end
        end
      end
      sse_pkg::ST_PASS: begin
        ram_raddr         = i;
        rd_ctl_next.vld   = 1'b1;
        rd_ctl_next.first = 1'b1;
        j_next            = i + AW'(1);
        state_next        = sse_pkg::ST_SCAN;
      end
      sse_pkg::ST_SCAN: begin
        ram_raddr       = j;
        rd_ctl_next.vld = 1'b1;
        if (CW'(j) == count - CW'(1)) begin
          state_next = sse_pkg::ST_DRAIN;
        end else begin
          j_next = j + AW'(1);
        end
      end
      sse_pkg::ST_DRAIN: begin
        // The last word of the pass is folded into the minimum here.
        state_next = sse_pkg::ST_SWAP_A;
      end
      sse_pkg::ST_SWAP_A: begin
        ram_we     = (min_idx != i);
        ram_waddr  = min_idx;
        ram_wdata  = head_val;
        state_next = sse_pkg::ST_SWAP_B;
      end
      sse_pkg::ST_SWAP_B: begin
        ram_we    = (min_idx != i);
        ram_waddr = i;
        ram_wdata = min_val;
        i_next    = i + AW'(1);
        if (CW'(i) + CW'(2) < count) begin
          state_next = sse_pkg::ST_PASS;
        end else begin
          state_next = sse_pkg::ST_OUT_RD;
        end
      end
      sse_pkg::ST_OUT_RD: begin
        ram_raddr  = k;
        state_next = sse_pkg::ST_OUT_CAP;
      end
      sse_pkg::ST_OUT_CAP: begin
        out_valid_next = 1'b1;
        state_next     = sse_pkg::ST_OUT_HOLD;
      end
      sse_pkg::ST_OUT_HOLD: begin
        if (out_acc) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = sse_pkg::ST_LOAD;
          end else begin
            k_next     = k + AW'(1);
            state_next = sse_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = sse_pkg::ST_LOAD;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output requests open at the same time");

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == sse_pkg::ST_PASS || state == sse_pkg::ST_SCAN ||
     state == sse_pkg::ST_SWAP_A || state == sse_pkg::ST_SWAP_B) |-> count >= CW'(2))
    else $error("sort pass started on a list shorter than two");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && count == '0 && !ovf))
    else $error("list state not cleared after the final result");

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [sse_pkg::VALUE_W-1:0] value;
    logic                        last;
    bit                          drain_first;
  } request_t;

  typedef struct packed {
    logic [sse_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        overflow;
  } sorted_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [sse_pkg::VALUE_W-1:0] s_tdata = '0;
  logic                        s_tlast = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [sse_pkg::VALUE_W-1:0] m_tdata;
  logic                        m_tlast;
  logic                        m_tuser;

  request_t     pending[$];
  sorted_word_t sorted_expect[$];

  // Software copy of the list being collected.
  logic signed [sse_pkg::VALUE_W-1:0] list_store [DEPTH];
  int unsigned                        list_len = 0;
  bit                                 list_dropped = 1'b0;

  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  selection_sort_engine #(.MAX_ELEMENTS(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender: offers queued requests and predicts the sorted output when a list's closing request is accepted.
  always @(posedge clk) begin : drive
    request_t                           req;
    sorted_word_t                       word;
    logic signed [sse_pkg::VALUE_W-1:0] swap_word;
    int unsigned                        low_at;
    bit                                 busy;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
    end else begin
      busy = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        requests_taken++;
        if (list_len < DEPTH) begin
          list_store[list_len] = s_tdata;
          list_len++;
        end else begin
          list_dropped = 1'b1;
        end
        if (s_tlast) begin
          for (int i = 0; i + 1 < list_len; i++) begin
            low_at = i;
            for (int j = i + 1; j < list_len; j++) begin
              if (list_store[j] < list_store[low_at]) low_at = j;
            end
            swap_word = list_store[low_at];
            list_store[low_at] = list_store[i];
            list_store[i] = swap_word;
          end
          for (int k = 0; k < list_len; k++) begin
            word.value = list_store[k];
            word.last = (k + 1 == list_len);
            word.overflow = list_dropped;
            sorted_expect.push_back(word);
          end
          list_len = 0;
          list_dropped = 1'b0;
        end
      end
      if (!busy) begin
        if (pending.size() != 0 && !(pending[0].drain_first && sorted_expect.size() != 0) &&
            ((requests_taken >= 150 && requests_taken < 185) || $urandom_range(99) >= 13)) begin
          req = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= req.value;
          s_tlast <= req.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_used && results_seen >= 40) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (results_seen >= 150 && results_seen < 200) || $urandom_range(99) >= 13;
      end
    end
  end

  always @(posedge clk) begin : observe
    sorted_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sorted_expect.size() == 0) begin
        $display("%0t: unexpected result value %h last %b overflow %b",
                 $time, m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = sorted_expect.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: sorted_value expected %h actual %h", $time, want.value, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_result expected %b actual %b", $time, want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_request(input logic [sse_pkg::VALUE_W-1:0] value, input logic last,
                              input bit drain_first);
    request_t req;
    req.value = value;
    req.last = last;
    req.drain_first = drain_first;
    pending.push_back(req);
  endtask

  function automatic logic [sse_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      // A narrow range makes repeated values common.
      2, 3: return $urandom_range(8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_list(input int unsigned len, input bit drain_first);
    for (int unsigned i = 0; i < len; i++) begin
      push_request(pick_value(), i + 1 == len, drain_first && i == 0);
    end
  endtask

  task automatic push_short_lists(input int unsigned total);
    int unsigned made;
    int unsigned len;
    made = 0;
    while (made < total) begin
      len = ($urandom_range(5) == 0) ? 1 : $urandom_range(12, 2);
      push_list(len, $urandom_range(4) == 0);
      made += len;
    end
  endtask

  initial begin
    logic [sse_pkg::VALUE_W-1:0] extremes [7];
    logic [sse_pkg::VALUE_W-1:0] repeats [5];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000};
    repeats = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3};

    // Single-element list.
    push_request(32'h7FFF_FFFF, 1'b1, 1'b0);
    foreach (extremes[i]) push_request(extremes[i], i == 6, 1'b0);
    foreach (repeats[i]) push_request(repeats[i], i == 4, 1'b0);
    for (int i = 0; i < 3; i++) push_request(32'h8000_0000, i == 2, 1'b0);
    // Strictly descending input needs a swap on each pass up to the middle of the list.
    for (int i = 0; i < 6; i++) push_request(300 - 100 * i, i == 5, 1'b0);

    // Overflowing list: two extra items, the closing one among the dropped.
    push_list(DEPTH + 2, 1'b1);
    push_short_lists(30);
    push_list(DEPTH, 1'b1);
    push_short_lists(30);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sse_pkg.sv
rtl/core/sse_ram.sv
rtl/core/sse_min_unit.sv
rtl/core/selection_sort_engine.sv
test/testbench.sv
